// ----- rtl/dap_pkg.sv -----
// Package for the dihedral angle block: widths, constants, stage types and helpers.
// No dependencies; used by every file in rtl.
`default_nettype none

package dap_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_STAGES = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NORM_BITS    = 30;
  localparam int HALF_PI_Q30  = 1686629713;
  localparam int TORSION_MAX  = 25736;
  localparam int OUT_W        = 16;
  localparam int OUT_SHIFT    = 17;

  localparam int DW   = COORD_WIDTH + 1;       // bond vector component
  localparam int PW   = 2 * DW;                // cross product term
  localparam int NW   = PW + 1;                // normal component
  localparam int TL   = NW / 2;                // low slice of normal for triple product
  localparam int TH   = NW - TL;
  localparam int PLW  = TL + 1 + DW;
  localparam int PHW  = TH + DW;
  localparam int TW   = NW + DW + 2;           // triple product
  localparam int NLW  = $clog2(NW + 1);
  localparam int RW   = NORM_BITS + 1;         // reduced normal, signed
  localparam int QW   = 2 * RW;
  localparam int XW   = QW + 2;                // dot and cross of reduced normals
  localparam int XLW  = $clog2(XW + 1);
  localparam int SSW  = 2 * NORM_BITS + 2;     // sum of squares
  localparam int SQ_CELLS = SSW / 2;
  localparam int RMW  = SQ_CELLS + 3;          // square root remainder
  localparam int AW   = NORM_BITS + 4;         // CORDIC x, y, z
  localparam int SHW  = $clog2(ATAN_ENTRIES);

  typedef struct packed {
    logic vld;
    logic neg;
    logic degen;
  } dap_side_t;

  typedef struct packed {
    logic [SSW-1:0]        rad;
    logic [RMW-1:0]        rem;
    logic [SQ_CELLS-1:0]   root;
    logic signed [RW-1:0]  x;
    dap_side_t             side;
  } dap_sq_t;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
    dap_side_t            side;
  } dap_cr_t;

  // atan(2^-i), 30 fraction bits, truncated
  function automatic logic signed [AW-1:0] atan_q30(input int idx);
    logic signed [AW-1:0] r;
    case (idx)
      0:  r = AW'(32'sh3243F6A8);
      1:  r = AW'(32'sh1DAC6705);
      2:  r = AW'(32'sh0FADBAFC);
      3:  r = AW'(32'sh07F56EA6);
      4:  r = AW'(32'sh03FEAB76);
      5:  r = AW'(32'sh01FFD55B);
      6:  r = AW'(32'sh00FFFAAA);
      7:  r = AW'(32'sh007FFF55);
      8:  r = AW'(32'sh003FFFEA);
      9:  r = AW'(32'sh001FFFFD);
      10: r = AW'(32'sh000FFFFF);
      11: r = AW'(32'sh0007FFFF);
      12: r = AW'(32'sh0003FFFF);
      13: r = AW'(32'sh0001FFFF);
      14: r = AW'(32'sh0000FFFF);
      15: r = AW'(32'sh00007FFF);
      16: r = AW'(32'sh00003FFF);
      17: r = AW'(32'sh00001FFF);
      18: r = AW'(32'sh00000FFF);
      19: r = AW'(32'sh000007FF);
      20: r = AW'(32'sh000003FF);
      21: r = AW'(32'sh000001FF);
      22: r = AW'(32'sh000000FF);
      23: r = AW'(32'sh0000007F);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [NLW-1:0] bitlen_n(input logic [NW-1:0] v);
    logic [NLW-1:0] r;
    r = '0;
    for (int i = 0; i < NW; i++) begin
      if (v[i]) r = NLW'(i + 1);
    end
    return r;
  endfunction

  function automatic logic [XLW-1:0] bitlen_x(input logic [XW-1:0] v);
    logic [XLW-1:0] r;
    r = '0;
    for (int i = 0; i < XW; i++) begin
      if (v[i]) r = XLW'(i + 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dihedral_angle_four_points_top.sv -----
// Top level of the dihedral angle block: front end, square root chain, CORDIC chain.
// Depends on dap_pkg, dap_sqrt_cell, dap_cordic_cell.
`default_nettype none

// Signed torsion angle of four points. A request is taken on every cycle in
// which start_i is high; busy_o never rises, so a new request can follow in
// the very next cycle. Each request gives one result, shown for one cycle
// with done_o; results leave in request order and the receiver cannot hold
// them off. The pipe is made of 14 front-end stages (bond vectors, normals,
// triple product, two normalisation passes, squares), a 31-cell square root
// chain, a pre-rotation register, one CORDIC cell per stage and the output
// register. torsion_o is in radians with 13 fraction bits; if either plane
// normal is zero (collinear points) torsion_o is 0 and degenerate_o is 1.
module dihedral_angle_four_points_top
  import dap_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] p1_x_i,
  input  logic signed [COORD_WIDTH-1:0] p1_y_i,
  input  logic signed [COORD_WIDTH-1:0] p1_z_i,
  input  logic signed [COORD_WIDTH-1:0] p2_x_i,
  input  logic signed [COORD_WIDTH-1:0] p2_y_i,
  input  logic signed [COORD_WIDTH-1:0] p2_z_i,
  input  logic signed [COORD_WIDTH-1:0] p3_x_i,
  input  logic signed [COORD_WIDTH-1:0] p3_y_i,
  input  logic signed [COORD_WIDTH-1:0] p3_z_i,
  input  logic signed [COORD_WIDTH-1:0] p4_x_i,
  input  logic signed [COORD_WIDTH-1:0] p4_y_i,
  input  logic signed [COORD_WIDTH-1:0] p4_z_i,
  output logic                          done_o,
  output logic signed [OUT_W-1:0]       torsion_o,
  output logic                          degenerate_o
);

  localparam int LATENCY = 14 + SQ_CELLS + 1 + ANGLE_STAGES + 1;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // side band per front-end stage: valid, triple product sign, collinear
  dap_side_t s_q [14];

  // stage 0: captured coordinates
  logic signed [COORD_WIDTH-1:0] c_q [12];
  // stage 1: bond vectors
  logic signed [DW-1:0] u_q [3], v_q [3], w1_q [3];
  // stage 2: cross product terms
  logic signed [PW-1:0] p1a_q [3], p1b_q [3], p2a_q [3], p2b_q [3];
  logic signed [DW-1:0] w2_q [3];
  // stage 3: normals
  logic signed [NW-1:0] n1_q [3], n2_q [3];
  logic signed [DW-1:0] w3_q [3];
  // stage 4: magnitudes and triple product partials
  logic [NW-1:0]         m1_q [3], m2_q [3];
  logic [2:0]            sg1_q, sg2_q;
  logic [NW-1:0]         or1_q, or2_q;
  logic signed [PLW-1:0] tlo_q [3];
  logic signed [PHW-1:0] thi_q [3];
  // stage 5: lengths
  logic [NW-1:0]  m1b_q [3], m2b_q [3];
  logic [2:0]     sg1b_q, sg2b_q;
  logic [NLW-1:0] len1_q, len2_q;
  // stage 6: reduced normals
  logic signed [RW-1:0] r1_q [3], r2_q [3];
  // stage 7: products
  logic signed [QW-1:0] pp_q [3][3];
  // stage 8: dot and cross
  logic signed [XW-1:0] xd_q [4];
  // stage 9: magnitudes
  logic [XW-1:0] xm_q [4];
  logic          xs_q;
  logic [XW-1:0] xor_q;
  // stage 10: length
  logic [XW-1:0]  xmb_q [4];
  logic           xsb_q;
  logic [XLW-1:0] xlen_q;
  // stage 11: scaled
  logic signed [RW-1:0]  x11_q;
  logic [NORM_BITS-1:0]  mm_q [3];
  // stage 12: squares
  logic signed [RW-1:0]      x12_q;
  logic [2*NORM_BITS-1:0]    sq_q [3];
  // stage 13 feeds the root chain
  dap_sq_t sq_head_q;

  // combinational next values
  logic signed [DW-1:0]  u_d [3], v_d [3], w_d [3];
  logic                  degen_d;
  logic signed [TW-1:0]  tri_d;
  logic [NLW-1:0]        sh1, sh2;
  logic [NORM_BITS-1:0]  a1 [3], a2 [3];
  logic [XLW-1:0]        xsh;
  logic [NORM_BITS-1:0]  xu [4];
  logic [SSW-1:0]        ss_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_d[i] = DW'(c_q[3 + i]) - DW'(c_q[i]);
      v_d[i] = DW'(c_q[6 + i]) - DW'(c_q[3 + i]);
      w_d[i] = DW'(c_q[9 + i]) - DW'(c_q[6 + i]);
    end
    degen_d = ((n1_q[0] == '0) && (n1_q[1] == '0) && (n1_q[2] == '0)) ||
              ((n2_q[0] == '0) && (n2_q[1] == '0) && (n2_q[2] == '0));
    tri_d = '0;
    for (int i = 0; i < 3; i++) begin
      tri_d = tri_d + (TW'(thi_q[i]) <<< TL) + TW'(tlo_q[i]);
    end
    sh1 = (len1_q > NLW'(NORM_BITS)) ? len1_q - NLW'(NORM_BITS) : '0;
    sh2 = (len2_q > NLW'(NORM_BITS)) ? len2_q - NLW'(NORM_BITS) : '0;
    // reduce each normal to 30 bits, truncating the magnitude
    for (int i = 0; i < 3; i++) begin
      a1[i] = NORM_BITS'(m1b_q[i] >> sh1);
      a2[i] = NORM_BITS'(m2b_q[i] >> sh2);
    end
    xsh = '0;
    for (int i = 0; i < 4; i++) xu[i] = '0;
    if (xlen_q > XLW'(NORM_BITS)) begin
      xsh = xlen_q - XLW'(NORM_BITS);
      for (int i = 0; i < 4; i++) xu[i] = NORM_BITS'(xmb_q[i] >> xsh);
    end else if (xlen_q != '0) begin
      xsh = XLW'(NORM_BITS) - xlen_q;
      for (int i = 0; i < 4; i++) xu[i] = NORM_BITS'(xmb_q[i] << xsh);
    end else begin
      for (int i = 0; i < 4; i++) xu[i] = NORM_BITS'(xmb_q[i]);
    end
    ss_d = SSW'(sq_q[0]) + SSW'(sq_q[1]) + SSW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 14; i++) s_q[i] <= '0;
    end else begin
      s_q[0] <= '{vld: accept, neg: 1'b0, degen: 1'b0};
      s_q[1] <= s_q[0];
      s_q[2] <= s_q[1];
      s_q[3] <= s_q[2];
      s_q[4] <= '{vld: s_q[3].vld, neg: 1'b0, degen: degen_d};
      s_q[5] <= '{vld: s_q[4].vld, neg: tri_d[TW-1], degen: s_q[4].degen};
      for (int i = 6; i < 14; i++) s_q[i] <= s_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q[0]  <= p1_x_i;  c_q[1]  <= p1_y_i;  c_q[2]  <= p1_z_i;
      c_q[3]  <= p2_x_i;  c_q[4]  <= p2_y_i;  c_q[5]  <= p2_z_i;
      c_q[6]  <= p3_x_i;  c_q[7]  <= p3_y_i;  c_q[8]  <= p3_z_i;
      c_q[9]  <= p4_x_i;  c_q[10] <= p4_y_i;  c_q[11] <= p4_z_i;
    end
    for (int i = 0; i < 3; i++) begin
      u_q[i]  <= u_d[i];
      v_q[i]  <= v_d[i];
      w1_q[i] <= w_d[i];
      // cross product terms
      p1a_q[i] <= PW'(u_q[(i + 1) % 3]) * PW'(v_q[(i + 2) % 3]);
      p1b_q[i] <= PW'(u_q[(i + 2) % 3]) * PW'(v_q[(i + 1) % 3]);
      p2a_q[i] <= PW'(v_q[(i + 1) % 3]) * PW'(w1_q[(i + 2) % 3]);
      p2b_q[i] <= PW'(v_q[(i + 2) % 3]) * PW'(w1_q[(i + 1) % 3]);
      w2_q[i]  <= w1_q[i];
      n1_q[i]  <= NW'(p1a_q[i]) - NW'(p1b_q[i]);
      n2_q[i]  <= NW'(p2a_q[i]) - NW'(p2b_q[i]);
      w3_q[i]  <= w2_q[i];
      // magnitudes, and triple product split into two short multiplies
      m1_q[i]  <= n1_q[i][NW-1] ? NW'(-n1_q[i]) : NW'(n1_q[i]);
      m2_q[i]  <= n2_q[i][NW-1] ? NW'(-n2_q[i]) : NW'(n2_q[i]);
      sg1_q[i] <= n1_q[i][NW-1];
      sg2_q[i] <= n2_q[i][NW-1];
      tlo_q[i] <= PLW'($signed({1'b0, n1_q[i][TL-1:0]})) * PLW'(w3_q[i]);
      thi_q[i] <= PHW'($signed(n1_q[i][NW-1:TL])) * PHW'(w3_q[i]);
      m1b_q[i] <= m1_q[i];
      m2b_q[i] <= m2_q[i];
    end
    or1_q  <= (n1_q[0][NW-1] ? NW'(-n1_q[0]) : NW'(n1_q[0])) |
              (n1_q[1][NW-1] ? NW'(-n1_q[1]) : NW'(n1_q[1])) |
              (n1_q[2][NW-1] ? NW'(-n1_q[2]) : NW'(n1_q[2]));
    or2_q  <= (n2_q[0][NW-1] ? NW'(-n2_q[0]) : NW'(n2_q[0])) |
              (n2_q[1][NW-1] ? NW'(-n2_q[1]) : NW'(n2_q[1])) |
              (n2_q[2][NW-1] ? NW'(-n2_q[2]) : NW'(n2_q[2]));
    sg1b_q <= sg1_q;
    sg2b_q <= sg2_q;
    len1_q <= bitlen_n(or1_q);
    len2_q <= bitlen_n(or2_q);
    for (int i = 0; i < 3; i++) begin
      r1_q[i] <= sg1b_q[i] ? -RW'(a1[i]) : RW'(a1[i]);
      r2_q[i] <= sg2b_q[i] ? -RW'(a2[i]) : RW'(a2[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_q[i][j] <= QW'(r1_q[i]) * QW'(r2_q[j]);
      end
    end
    xd_q[0] <= XW'(pp_q[0][0]) + XW'(pp_q[1][1]) + XW'(pp_q[2][2]);
    xd_q[1] <= XW'(pp_q[1][2]) - XW'(pp_q[2][1]);
    xd_q[2] <= XW'(pp_q[2][0]) - XW'(pp_q[0][2]);
    xd_q[3] <= XW'(pp_q[0][1]) - XW'(pp_q[1][0]);
    for (int i = 0; i < 4; i++) begin
      xm_q[i]  <= xd_q[i][XW-1] ? XW'(-xd_q[i]) : XW'(xd_q[i]);
      xmb_q[i] <= xm_q[i];
    end
    xs_q  <= xd_q[0][XW-1];
    xor_q <= (xd_q[0][XW-1] ? XW'(-xd_q[0]) : XW'(xd_q[0])) |
             (xd_q[1][XW-1] ? XW'(-xd_q[1]) : XW'(xd_q[1])) |
             (xd_q[2][XW-1] ? XW'(-xd_q[2]) : XW'(xd_q[2])) |
             (xd_q[3][XW-1] ? XW'(-xd_q[3]) : XW'(xd_q[3]));
    xsb_q  <= xs_q;
    xlen_q <= bitlen_x(xor_q);
    x11_q  <= xsb_q ? -RW'(xu[0]) : RW'(xu[0]);
    for (int i = 0; i < 3; i++) begin
      mm_q[i] <= xu[i + 1];
      sq_q[i] <= (2*NORM_BITS)'(mm_q[i]) * (2*NORM_BITS)'(mm_q[i]);
    end
    x12_q <= x11_q;
    sq_head_q.rad  <= ss_d;
    sq_head_q.rem  <= '0;
    sq_head_q.root <= '0;
    sq_head_q.x    <= x12_q;
    sq_head_q.side <= s_q[12];
  end

  // square root chain; valid travels in s_q[13]
  dap_sq_t sq_head;
  dap_sq_t sq_chain [SQ_CELLS+1];

  always_comb begin
    sq_head          = sq_head_q;
    sq_head.side     = s_q[13];
    sq_chain[0]      = sq_head;
  end

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    dap_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (sq_chain[k]),
      .d_o    (sq_chain[k+1])
    );
  end

  // pre-rotation by pi/2 for a negative dot product
  dap_sq_t    sq_tail;
  dap_cr_t    pre_d;
  logic       pre_vld_q;
  dap_cr_t    pre_q;

  always_comb begin
    sq_tail    = sq_chain[SQ_CELLS];
    pre_d.side = sq_tail.side;
    if (sq_tail.x < 0) begin
      pre_d.x = AW'(sq_tail.root);
      pre_d.y = -AW'(sq_tail.x);
      pre_d.z = AW'(HALF_PI_Q30);
    end else begin
      pre_d.x = AW'(sq_tail.x);
      pre_d.y = AW'(sq_tail.root);
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pre_vld_q <= 1'b0;
    else         pre_vld_q <= sq_tail.side.vld;
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
  end

  dap_cr_t cr_chain [ANGLE_STAGES+1];

  always_comb begin
    cr_chain[0]          = pre_q;
    cr_chain[0].side.vld = pre_vld_q;
  end

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cordic
    dap_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sh_i   (SHW'(k)),
      .at_i   (atan_q30(k)),
      .skip_i (k >= ATAN_ENTRIES),
      .d_i    (cr_chain[k]),
      .d_o    (cr_chain[k+1])
    );
  end

  // output: clamp, round half up to 13 fraction bits, clamp, apply sign
  dap_cr_t              cr_tail;
  logic signed [AW-1:0] zc, qw, qc;
  logic signed [OUT_W-1:0] tor_d;
  logic                 done_q;
  logic signed [OUT_W-1:0] tor_q;
  logic                 degen_q;

  always_comb begin
    cr_tail = cr_chain[ANGLE_STAGES];
    zc      = cr_tail.z[AW-1] ? '0 : cr_tail.z;
    qw      = (zc + AW'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    qc      = (qw > AW'(TORSION_MAX)) ? AW'(TORSION_MAX) : qw;
    if (cr_tail.side.degen)     tor_d = '0;
    else if (cr_tail.side.neg)  tor_d = -OUT_W'(qc);
    else                        tor_d = OUT_W'(qc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= cr_tail.side.vld;
  end

  always_ff @(posedge clk_i) begin
    tor_q   <= tor_d;
    degen_q <= cr_tail.side.degen;
  end

  assign done_o       = done_q;
  assign torsion_o    = tor_q;
  assign degenerate_o = degen_q;

  // checks
  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> torsion_o == '0)
    else $error("collinear result with non-zero angle");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (torsion_o <= TORSION_MAX) && (torsion_o >= -TORSION_MAX))
    else $error("angle out of range");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("request lost in pipe");

endmodule

`default_nettype wire

// ----- rtl/dap_sqrt_cell.sv -----
// One digit cell of the square root chain: one root bit per cell, registered.
// Depends on dap_pkg.
`default_nettype none

module dap_sqrt_cell
  import dap_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dap_sq_t d_i,
  output dap_sq_t d_o
);

  logic [RMW-1:0] r2;
  logic [RMW-1:0] trial;
  dap_sq_t        nx;

  always_comb begin
    r2    = {d_i.rem[RMW-3:0], d_i.rad[SSW-1:SSW-2]};
    trial = RMW'({d_i.root, 2'b01});
    nx    = d_i;
    nx.rad = d_i.rad << 2;
    if (r2 >= trial) begin
      nx.rem  = r2 - trial;
      nx.root = {d_i.root[SQ_CELLS-2:0], 1'b1};
    end else begin
      nx.rem  = r2;
      nx.root = {d_i.root[SQ_CELLS-2:0], 1'b0};
    end
  end

  logic    vld_q;
  dap_sq_t pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= d_i.side.vld;
  end

  always_ff @(posedge clk_i) begin
    pay_q <= nx;
  end

  always_comb begin
    d_o          = pay_q;
    d_o.side.vld = vld_q;
  end

endmodule

`default_nettype wire

// ----- rtl/dap_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation, registered.
// Depends on dap_pkg.
`default_nettype none

module dap_cordic_cell
  import dap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SHW-1:0]       sh_i,
  input  logic signed [AW-1:0] at_i,
  input  logic                 skip_i,
  input  dap_cr_t              d_i,
  output dap_cr_t              d_o
);

  logic signed [AW-1:0] xs, ys;
  dap_cr_t              nx;

  always_comb begin
    xs = d_i.x >>> sh_i;
    ys = d_i.y >>> sh_i;
    nx = d_i;
    if (!skip_i) begin
      if (d_i.y > 0) begin
        nx.x = d_i.x + ys;
        nx.y = d_i.y - xs;
        nx.z = d_i.z + at_i;
      end else begin
        nx.x = d_i.x - ys;
        nx.y = d_i.y + xs;
        nx.z = d_i.z - at_i;
      end
    end
  end

  logic    vld_q;
  dap_cr_t pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= d_i.side.vld;
  end

  always_ff @(posedge clk_i) begin
    pay_q <= nx;
  end

  always_comb begin
    d_o          = pay_q;
    d_o.side.vld = vld_q;
  end

endmodule

`default_nettype wire
